// ----- sv/abre_pkg.sv -----
// Shared types and constants of the adaptive binary range encoder.
package abre_pkg;

   localparam int CONTEXTS_DEFAULT = 64;

   localparam int CMD_W      = 2;
   localparam int CTX_IN_W   = 6;
   localparam int CTX_IN_N   = 1 << CTX_IN_W;
   localparam int BITS_W     = 16;
   localparam int COUNT_W    = 5;
   localparam int PROB_W     = 12;
   localparam int RANGE_W    = 32;
   localparam int LOW_W      = 33;
   localparam int PEND_W     = 32;
   localparam int SHIFT_CNT_W = 3;

   localparam logic [CMD_W-1:0] CMD_CODED  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BYPASS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_START  = 2'd3;

   localparam logic [COUNT_W-1:0]     BYPASS_MAX   = 5'd16;
   localparam logic [PROB_W-1:0]      PROB_INIT    = 12'd2048;
   localparam logic [PROB_W:0]        PROB_ONE     = 13'd4096;
   localparam logic [SHIFT_CNT_W-1:0] FLUSH_SHIFTS = 3'd5;
   localparam logic [7:0]             BYTE_ONES    = 8'hFF;

   typedef enum logic [1:0] {
      OP_CODED,
      OP_BYPASS,
      OP_FLUSH,
      OP_START
   } op_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MULT,
      ST_APPLY,
      ST_SHIFT
   } back_state_type;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [CTX_IN_W-1:0] context_index;
      logic [BITS_W-1:0]   bits;
      logic [COUNT_W-1:0]  bit_count;
   } req_type;

   typedef struct packed {
      logic [7:0]        lead_byte;
      logic [7:0]        fill_byte;
      logic [PEND_W-1:0] fill_count;
      logic              last;
   } rsp_type;

   // Classified operation handed from the front to the back.
   typedef struct packed {
      op_kind_type         kind;
      logic [CTX_IN_W-1:0] ctx;
      logic [BITS_W-1:0]   value;
      logic [COUNT_W-1:0]  count;
   } op_type;

endpackage

// ----- sv/abre_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module abre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/abre_front.sv -----
// Front end: accepts commands, reduces contexts, clamps and masks bypass bits.
module abre_front import abre_pkg::*; #(
   parameter int CONTEXTS = CONTEXTS_DEFAULT
) (
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push_valid,
   input  logic    push_ready,
   output op_type  push_op
);
   logic [CTX_IN_W-1:0] ctx_mod_table [CTX_IN_N];
   logic [COUNT_W-1:0]  count_clamped;
   logic [BITS_W-1:0]   bypass_mask;
   logic                drop;

   for (genvar g = 0; g < CTX_IN_N; g++) begin : g_ctx_mod
      assign ctx_mod_table[g] = CTX_IN_W'(g % CONTEXTS);
   end

   assign count_clamped = (req_data.bit_count > BYPASS_MAX) ? BYPASS_MAX : req_data.bit_count;
   assign bypass_mask   = {BITS_W{1'b1}} >> (BYPASS_MAX - count_clamped);

   always_comb begin
      push_op.ctx   = ctx_mod_table[req_data.context_index];
      push_op.count = count_clamped;
      push_op.value = req_data.bits & bypass_mask;
      drop          = 1'b0;
      unique case (req_data.command)
         CMD_CODED: begin
            push_op.kind  = OP_CODED;
            push_op.value = {{(BITS_W-1){1'b0}}, req_data.bits[0]};
         end
         CMD_BYPASS: begin
            push_op.kind = OP_BYPASS;
            // A bypass of zero bits changes nothing and is discarded here.
            drop         = (req_data.bit_count == '0);
         end
         CMD_FLUSH: begin
            push_op.kind = OP_FLUSH;
         end
         default: begin
            push_op.kind = OP_START;
         end
      endcase
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid && !drop;

endmodule

// ----- sv/abre_queue.sv -----
// Two-entry queue of classified operations between front and back.
module abre_queue import abre_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);
   op_type     entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ----- sv/abre_back.sv -----
// Back end: interval arithmetic, context memory, byte shifts and result register.
module abre_back import abre_pkg::*; #(
   parameter int CONTEXTS = CONTEXTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    op_valid,
   output logic    op_ready,
   input  op_type  op_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int ADDR_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
   localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(CONTEXTS - 1);

   back_state_type state_ff, state_in;
   op_type         op_ff, op_in;
   logic [LOW_W-1:0]       low_ff, low_in;
   logic [RANGE_W-1:0]     range_ff, range_in;
   logic [7:0]             cache_ff, cache_in;
   logic [PEND_W-1:0]      pend_ff, pend_in;
   logic [RANGE_W-1:0]     prod_ff, prod_in;
   logic [SHIFT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   flush_ff, flush_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [PROB_W-1:0] ram_wr_data, ram_rd_data;

   logic                   out_free, carry, emit, later_emits;
   logic [SHIFT_CNT_W-1:0] rem;
   logic [RANGE_W-1:0]     mul_a;
   logic [BITS_W-1:0]      mul_b;
   logic [47:0]            mul_full;
   logic [PROB_W-1:0]      p_up, p_dn;
   logic [LOW_W-1:0]       apply_low;
   logic [RANGE_W-1:0]     apply_range;
   logic [SHIFT_CNT_W-1:0] apply_cnt;

   abre_ram #(
      .WIDTH (PROB_W),
      .DEPTH (CONTEXTS)
   ) u_prob_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign carry    = low_ff[LOW_W-1];
   assign emit     = carry || (low_ff[31:24] != BYTE_ONES);
   assign rem      = cnt_ff - 3'd1;

   // Bytes that later shifts of the same transaction will examine are already in low.
   assign later_emits = ((rem >= 3'd1) && (low_ff[23:16] != BYTE_ONES)) ||
                        ((rem >= 3'd2) && (low_ff[15:8] != BYTE_ONES)) ||
                        ((rem >= 3'd3) && (low_ff[7:0] != BYTE_ONES)) ||
                        (rem >= 3'd4);

   // One multiplier serves both the coded bit and the bypass bits.
   always_comb begin
      if (op_ff.kind == OP_CODED) begin
         mul_a = {12'd0, range_ff[RANGE_W-1:12]};
         mul_b = {4'd0, ram_rd_data};
      end else begin
         mul_a = range_ff;
         mul_b = op_ff.value;
      end
      mul_full = {16'd0, mul_a} * {32'd0, mul_b};
   end

   always_comb begin
      p_up = ram_rd_data + PROB_W'((PROB_ONE - {1'b0, ram_rd_data}) >> 4);
      p_dn = ram_rd_data - (ram_rd_data >> 4);
      apply_low   = low_ff;
      apply_range = range_ff;
      if (op_ff.kind == OP_CODED) begin
         if (op_ff.value[0]) begin
            apply_low   = low_ff + {1'b0, prod_ff};
            apply_range = range_ff - prod_ff;
         end else begin
            apply_range = prod_ff;
         end
      end else begin
         apply_low = low_ff + {1'b0, prod_ff};
      end
      if (apply_range[31:24] != 8'd0) begin
         apply_cnt = 3'd0;
      end else if (apply_range[23:16] != 8'd0) begin
         apply_cnt = 3'd1;
      end else if (apply_range[15:8] != 8'd0) begin
         apply_cnt = 3'd2;
      end else begin
         apply_cnt = 3'd3;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (op_valid) begin
               unique case (op_data.kind)
                  OP_START: state_in = ST_CLEAR;
                  OP_FLUSH: state_in = ST_SHIFT;
                  default:  state_in = ST_MULT;
               endcase
            end
         end
         ST_MULT: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = (apply_cnt != 3'd0) ? ST_SHIFT : ST_IDLE;
         end
         ST_SHIFT: begin
            if (out_free && (cnt_ff == 3'd1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      low_in       = low_ff;
      range_in     = range_ff;
      cache_in     = cache_ff;
      pend_in      = pend_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      flush_in     = flush_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ADDR_W'(op_ff.ctx);
      ram_wr_data  = PROB_INIT;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ADDR_W'(op_data.ctx);
      op_ready     = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (op_valid) begin
               op_in     = op_data;
               ram_rd_en = 1'b1;
               unique case (op_data.kind)
                  OP_BYPASS: begin
                     range_in = range_ff >> op_data.count;
                  end
                  OP_FLUSH: begin
                     cnt_in   = FLUSH_SHIFTS;
                     flush_in = 1'b1;
                  end
                  OP_START: begin
                     low_in   = '0;
                     range_in = '1;
                     cache_in = '0;
                     pend_in  = PEND_W'(1);
                     clr_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MULT: begin
            prod_in = mul_full[RANGE_W-1:0];
         end
         ST_APPLY: begin
            low_in   = apply_low;
            range_in = apply_range;
            cnt_in   = apply_cnt;
            flush_in = 1'b0;
            if (op_ff.kind == OP_CODED) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = op_ff.value[0] ? p_dn : p_up;
            end
         end
         ST_SHIFT: begin
            if (out_free) begin
               cnt_in = cnt_ff - 3'd1;
               low_in = {1'b0, low_ff[23:0], 8'd0};
               if (!flush_ff) begin
                  range_in = range_ff << 8;
               end
               if (emit) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.lead_byte  = cache_ff + {7'd0, carry};
                  rsp_in.fill_byte  = carry ? 8'h00 : BYTE_ONES;
                  rsp_in.fill_count = pend_ff - PEND_W'(1);
                  rsp_in.last       = !later_emits;
                  cache_in          = low_ff[31:24];
                  pend_in           = PEND_W'(1);
               end else if (pend_ff != '1) begin
                  pend_in = pend_ff + PEND_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         low_ff       <= '0;
         range_ff     <= '1;
         cache_ff     <= '0;
         pend_ff      <= PEND_W'(1);
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         low_ff       <= low_in;
         range_ff     <= range_in;
         cache_ff     <= cache_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/adaptive_binary_range_encoder.sv -----
// Top level of the adaptive binary range encoder.
//
//   port group  direction  handshake             payload
//   req_        in         req_valid/req_ready   req_data (req_type)
//   rsp_        out        rsp_valid/rsp_ready   rsp_data (rsp_type)
//
// A coded bit or bypass transaction passes the back-end states IDLE, MULT and APPLY,
// then SHIFT once per renormalizing byte shift (0 to 3); a flush makes five byte shifts
// and a start clears all CONTEXTS entries. The shared multiplier and the registered-read
// context memory with its single write port set this sequence of states.
// After reset the back end clears the context memory; the two-entry queue fills
// meanwhile and then holds req_ready low.
// A byte shift waits while the result register is full and not taken.
module adaptive_binary_range_encoder import abre_pkg::*; #(
   parameter int CONTEXTS = CONTEXTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic   push_valid, push_ready;
   op_type push_op;
   logic   pop_valid, pop_ready;
   op_type pop_op;

   abre_front #(
      .CONTEXTS (CONTEXTS)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   abre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   abre_back #(
      .CONTEXTS (CONTEXTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (pop_valid),
      .op_ready  (pop_ready),
      .op_data   (pop_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/sv/tb_adaptive_binary_range_encoder.sv -----
// Self-checking testbench for the adaptive binary range encoder.
module tb_adaptive_binary_range_encoder;
   import abre_pkg::*;

   localparam logic [31:0] RANGE_FLOOR  = 32'h0100_0000;
   localparam logic [31:0] RANGE_FULL   = 32'hFFFF_FFFF;
   localparam logic [32:0] SHIFT_LIMIT  = 33'h0_FF00_0000;
   localparam int          QUIET_CYCLES = 120;
   localparam int          PHASE_ITEMS  = 115;

   // Predicts the byte runs released by the encoder and checks them in order.
   class byte_run_board;
      logic [32:0] low;
      logic [31:0] span;
      logic [7:0]  cache;
      logic [31:0] run_len;
      logic [PROB_W-1:0] prob [CTX_IN_N];
      rsp_type runs_due [$];
      int unsigned errors;
      int unsigned items_noted;
      int unsigned flushes;
      int unsigned starts;
      int unsigned runs_checked;
      int unsigned carries;
      logic [31:0] longest_fill;

      function new();
         errors       = 0;
         items_noted  = 0;
         flushes      = 0;
         starts       = 0;
         runs_checked = 0;
         carries      = 0;
         longest_fill = '0;
         restart();
      endfunction

      function void restart();
         low     = '0;
         span    = RANGE_FULL;
         cache   = '0;
         run_len = 32'd1;
         foreach (prob[i]) prob[i] = PROB_INIT;
      endfunction

      // A shift releases a run unless the top byte may still take a carry.
      function void shift_byte();
         rsp_type run;
         logic    carry;
         carry = low[32];
         if (carry || low < SHIFT_LIMIT) begin
            run.lead_byte  = cache + carry;
            run.fill_byte  = BYTE_ONES + carry;
            run.fill_count = run_len - 32'd1;
            run.last       = 1'b0;
            runs_due.push_back(run);
            cache   = low[31:24];
            run_len = '0;
         end
         if (run_len != '1) run_len = run_len + 32'd1;
         low = {1'b0, low[23:0], 8'h00};
      endfunction

      function void renormalize();
         while (span < RANGE_FLOOR) begin
            shift_byte();
            span = span << 8;
         end
      endfunction

      function void note_request(req_type item);
         logic [PROB_W-1:0]  p;
         logic [31:0]        r0;
         logic [COUNT_W-1:0] k;
         logic [31:0]        raw;
         logic [63:0]        addend;
         int                 queued;
         rsp_type            tail;
         queued = runs_due.size();
         items_noted++;
         case (op_kind_type'(item.command))
            OP_CODED: begin
               p  = prob[item.context_index];
               r0 = (span >> 12) * p;
               if (item.bits[0] == 1'b0) begin
                  span = r0;
                  p    = p + ((PROB_ONE - p) >> 4);
               end else begin
                  low  = low + r0;
                  span = span - r0;
                  p    = p - (p >> 4);
               end
               prob[item.context_index] = p;
               renormalize();
            end
            OP_BYPASS: begin
               if (item.bit_count != '0) begin
                  k      = (item.bit_count > BYPASS_MAX) ? BYPASS_MAX : item.bit_count;
                  span   = span >> k;
                  raw    = 32'(item.bits) & ((32'd1 << k) - 32'd1);
                  addend = 64'(raw) * 64'(span);
                  low    = low + addend[32:0];
                  renormalize();
               end
            end
            OP_FLUSH: begin
               flushes++;
               repeat (FLUSH_SHIFTS) shift_byte();
            end
            default: begin
               starts++;
               restart();
            end
         endcase
         if (runs_due.size() > queued) begin
            tail      = runs_due.pop_back();
            tail.last = 1'b1;
            runs_due.push_back(tail);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_run(rsp_type got);
         rsp_type want;
         if (runs_due.size() == 0) begin
            $error("unexpected byte run: lead 0x%0h fill 0x%0h count %0d last %0b",
                   got.lead_byte, got.fill_byte, got.fill_count, got.last);
            errors++;
            return;
         end
         want = runs_due.pop_front();
         runs_checked++;
         if (want.fill_byte != BYTE_ONES) carries++;
         if (want.fill_count > longest_fill) longest_fill = want.fill_count;
         compare_field("lead_byte", 32'(want.lead_byte), 32'(got.lead_byte));
         compare_field("fill_byte", 32'(want.fill_byte), 32'(got.fill_byte));
         compare_field("fill_count", want.fill_count, got.fill_count);
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int unsigned   send_idle_pct = 0;
   int unsigned   stall_pct     = 0;
   byte_run_board board;

   adaptive_binary_range_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_run(rsp_data);
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic req_type make_item(logic [CMD_W-1:0] command,
                                         logic [CTX_IN_W-1:0] ctx,
                                         logic [BITS_W-1:0] bits,
                                         logic [COUNT_W-1:0] count);
      req_type item;
      item.command       = command;
      item.context_index = ctx;
      item.bits          = bits;
      item.bit_count     = count;
      return item;
   endfunction

   // Mostly coded bits with skewed contexts so probabilities drift to the
   // extremes, bypass runs of all ones to build long fill runs, rare starts.
   function automatic req_type random_item();
      req_type     item;
      int unsigned pick;
      pick = $urandom_range(99);
      item = make_item(CMD_CODED, 6'($urandom_range(63)), 16'($urandom),
                       5'($urandom_range(1, 16)));
      if (pick < 55) begin
         if (item.context_index < 6'd16 && $urandom_range(15) != 0)
            item.bits[0] = item.context_index[0];
      end else if (pick < 86) begin
         item.command = CMD_BYPASS;
         if ($urandom_range(2) == 0) item.bits = '1;
         if ($urandom_range(19) == 0) item.bit_count = 5'($urandom_range(31));
      end else if (pick < 97) begin
         item.command = CMD_FLUSH;
      end else begin
         item.command = CMD_START;
      end
      return item;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(item);
   endtask

   // Holds the sender back until every predicted run has been taken.
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (board.runs_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic send_directed();
      send_item(make_item(CMD_FLUSH, 6'd0, 16'h0000, 5'd1));
      send_item(make_item(CMD_CODED, 6'd0, 16'h0000, 5'd0));
      send_item(make_item(CMD_CODED, 6'd63, 16'hFFFF, 5'd31));
      send_item(make_item(CMD_CODED, 6'd63, 16'hFFFE, 5'd16));
      send_item(make_item(CMD_CODED, 6'd0, 16'h0001, 5'd1));
      send_item(make_item(CMD_BYPASS, 6'd0, 16'hFFFF, 5'd16));
      send_item(make_item(CMD_BYPASS, 6'd63, 16'hFFFF, 5'd16));
      send_item(make_item(CMD_BYPASS, 6'd7, 16'h0000, 5'd1));
      send_item(make_item(CMD_BYPASS, 6'd7, 16'h5555, 5'd0));
      send_item(make_item(CMD_BYPASS, 6'd9, 16'hAAAA, 5'd31));
      send_item(make_item(CMD_BYPASS, 6'd9, 16'h0001, 5'd17));
      send_item(make_item(CMD_FLUSH, 6'd0, 16'h0000, 5'd1));
      // Encoding simply continues after a flush.
      send_item(make_item(CMD_CODED, 6'd5, 16'h0001, 5'd1));
      repeat (3) send_item(make_item(CMD_BYPASS, 6'd0, 16'hFFFF, 5'd16));
      repeat (3) send_item(make_item(CMD_CODED, 6'd2, 16'h0001, 5'd1));
      send_item(make_item(CMD_START, 6'd0, 16'h0000, 5'd0));
      send_item(make_item(CMD_START, 6'd63, 16'hFFFF, 5'd31));
      send_item(make_item(CMD_FLUSH, 6'd0, 16'h0000, 5'd1));
      send_item(make_item(CMD_CODED, 6'd1, 16'h0000, 5'd1));
      send_item(make_item(CMD_FLUSH, 6'd0, 16'h0000, 5'd1));
   endtask

   initial begin
      int unsigned idle_plan [4];
      int unsigned stall_plan [4];
      idle_plan  = '{0, 77, 0, 23};
      stall_plan = '{0, 0, 77, 23};
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_directed();
      wait_for_quiet();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_plan[phase];
         stall_pct     = stall_plan[phase];
         repeat (PHASE_ITEMS) send_item(random_item());
         wait_for_quiet();
      end
      $display("Encoded %0d transactions (%0d flushes, %0d stream starts), %0d byte runs checked.",
               board.items_noted, board.flushes, board.starts, board.runs_checked);
      $display("Runs carrying into the lead byte: %0d; longest fill run: %0d bytes.",
               board.carries, board.longest_fill);
      if (board.errors == 0 && board.runs_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/abre_pkg.sv
sv/abre_ram.sv
sv/abre_front.sv
sv/abre_queue.sv
sv/abre_back.sv
sv/adaptive_binary_range_encoder.sv
tb/sv/tb_adaptive_binary_range_encoder.sv
